[rtl/core/assert_macros.svh]
// Assertion macros used by the record verifier core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, except while reset is high.
`define ASSERT_CLK(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) \
    else $error(msg);

// Check that a condition never holds, except while reset is high.
`define ASSERT_NEVER(lbl, clk_sig, rst_sig, cond, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) !(cond)) \
    else $error(msg);

`endif

[rtl/core/crc32rv_pkg.sv]
// Constants, register indexes and the byte-wide CRC update for the record verifier.
package crc32rv_pkg;

  localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;
  localparam logic [31:0] CRC_XOROUT      = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_START_RESET = 32'h5555_5555;

  localparam int unsigned TAIL_DEPTH = 4;
  localparam logic [2:0]  TAIL_FULL  = 3'd4;

  typedef enum logic [1:0] {
    CFG_RECORD_MODE   = 2'd0,
    CFG_REPAIR_ENABLE = 2'd1,
    CFG_CRC_START     = 2'd2
  } cfg_index_t;

  typedef logic [7:0] byte_t;

  // Reflected CRC-32, one byte, LSB first.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input byte_t b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[rtl/core/crc32_record_verify_core.sv]
// Record CRC-32 verifier: byte update, stored-CRC delay line, compare and result register.
// out_valid rises in the cycle after the request carrying last is taken.
// Throughput: one byte per cycle while in_ready is high; the single byte-wide CRC update sets the pace.
// A new request is taken while a result waits, provided it is being taken this cycle.
// Reset (rst, synchronous): record_mode 1, repair_enable 0, crc_start 0x55555555,
// delay line empty, CRC unseeded, no result pending.
`include "assert_macros.svh"

module crc32_record_verify_core (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // byte stream
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] crc_value,
  output logic        crc_match,
  output logic        write_back,
  output logic        too_short
);

  logic        record_mode;
  logic        repair_enable;
  logic [31:0] crc_start;

  logic [31:0] crc_register;
  logic        seeded;
  crc32rv_pkg::byte_t tail_bytes [crc32rv_pkg::TAIL_DEPTH];
  logic [2:0]  tail_fill;

  logic        in_fire;
  logic        do_cover;
  crc32rv_pkg::byte_t cover_byte;
  logic [31:0] crc_base;
  logic [31:0] crc_updated;
  logic [31:0] crc_final;
  logic [2:0]  tail_fill_next;
  logic [31:0] stored_crc;
  logic        short_rec;
  logic        crc_equal;
  logic        out_valid_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      record_mode   <= 1'b1;
      repair_enable <= 1'b0;
      crc_start     <= crc32rv_pkg::CRC_START_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        crc32rv_pkg::CFG_RECORD_MODE:   record_mode   <= cfg_data[0];
        crc32rv_pkg::CFG_REPAIR_ENABLE: repair_enable <= cfg_data[0];
        crc32rv_pkg::CFG_CRC_START:     crc_start     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    // in record mode the oldest held byte enters the CRC once four are held
    do_cover   = record_mode ? (tail_fill == crc32rv_pkg::TAIL_FULL) : 1'b1;
    cover_byte = record_mode ? tail_bytes[0] : data_byte;
    crc_base   = seeded ? crc_register : crc_start;
    crc_updated = crc32rv_pkg::crc_byte(crc_base, cover_byte);
    crc_final  = (do_cover ? crc_updated : crc_base) ^ crc32rv_pkg::CRC_XOROUT;

    if (record_mode) begin
      tail_fill_next = (tail_fill == crc32rv_pkg::TAIL_FULL) ? crc32rv_pkg::TAIL_FULL
                                                           : tail_fill + 3'd1;
    end else begin
      tail_fill_next = tail_fill;
    end

    // stored CRC after the shift, least significant byte oldest
    stored_crc = {data_byte, tail_bytes[3], tail_bytes[2], tail_bytes[1]};
    short_rec  = record_mode && (tail_fill_next != crc32rv_pkg::TAIL_FULL);
    crc_equal  = (stored_crc == crc_final);
  end

  // CRC and delay line state
  always_ff @(posedge clk) begin
    if (rst) begin
      seeded    <= 1'b0;
      tail_fill <= 3'd0;
    end else if (in_fire) begin
      if (last) begin
        seeded    <= 1'b0;
        tail_fill <= 3'd0;
      end else begin
        seeded    <= seeded || do_cover;
        tail_fill <= tail_fill_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (do_cover) begin
        crc_register <= crc_updated;
      end
      if (record_mode) begin
        tail_bytes[0] <= tail_bytes[1];
        tail_bytes[1] <= tail_bytes[2];
        tail_bytes[2] <= tail_bytes[3];
        tail_bytes[3] <= data_byte;
      end
    end
  end

  // result register
  always_comb begin
    priority if (in_fire && last) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && last) begin
      too_short <= short_rec;
      if (!record_mode) begin
        crc_value  <= crc_final;
        crc_match  <= 1'b1;
        write_back <= 1'b0;
      end else if (short_rec) begin
        // nothing to compare; bytes covered earlier in plain mode still count
        crc_value  <= crc_final;
        crc_match  <= 1'b0;
        write_back <= 1'b0;
      end else begin
        crc_value  <= crc_final;
        crc_match  <= crc_equal;
        write_back <= !crc_equal && repair_enable;
      end
    end
  end

  `ASSERT_CLK(a_fill_bound, clk, rst, tail_fill <= crc32rv_pkg::TAIL_FULL, "tail_fill beyond four")
  `ASSERT_CLK(a_last_gives_result, clk, rst, in_fire && last |=> out_valid, "last without result")
  `ASSERT_CLK(a_end_clears, clk, rst, in_fire && last |=> tail_fill == 3'd0 && !seeded, "not cleared")
  `ASSERT_NEVER(a_short_flags, clk, rst, out_valid && too_short && (crc_match || write_back), "short")

endmodule
